FILE: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared package
// Beat payload types, sequencer states, control bundle, round constants,
// initial hash values and the sigma functions of the compression.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Input beat: one optional message byte and an end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha256_in_t;

  // Output beat: one digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha256_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sha256_state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic load_byte;
    logic load_vars;
    logic round_en;
    logic fold;
    logic rotate;
    logic reinit;
  } sha256_ctl_t;

  localparam int unsigned COUNT_W  = 61;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [5:0]  LAST_RND = 6'd63;
  localparam logic [2:0]  LAST_WORD = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/core/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest engine
// Gathers message bytes into 64-byte blocks, compresses each block with one
// round per cycle, pads at end of message and returns eight digest words.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while idle; every 64th byte stalls the input
//   for the block's 64 rounds in the round unit plus one fold step.
// End of message: padding bytes fill out each padded block, which then runs its
//   rounds and fold (one or two blocks), then eight output beats.
// Reset: synchronous on rst_n low; hash words return to their initial values,
//   the byte count clears and the engine is idle. There is no clearing pass.
module sha256_message_digest (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sha256_pkg::sha256_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sha256_pkg::sha256_out_t  out_data
);
  import sha256_pkg::*;

  sha256_state_t       state_r, state_nxt;
  logic [5:0]          pos_r;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  count_inc;
  logic [5:0]          round_r;
  logic [2:0]          word_r;
  logic                padding_r;
  logic                first_r;
  logic                extra_r;
  logic                last_r;
  logic [63:0]         len_r;

  sha256_ctl_t         ctl;
  logic [7:0]          byte_mux;
  logic [7:0]          pad_byte;
  logic                len_sel;
  logic                in_acc;
  logic                out_acc;
  logic                wrap;
  logic [31:0]         w_head;
  logic [31:0]         hash_head;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign count_inc = count_r + COUNT_W'(1);
  assign wrap      = (pos_r == LAST_POS);

  // Padding byte: the marker first, then zeros, then the bit length.
  assign len_sel = !first_r && (pos_r >= LEN_POS) && !extra_r;
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_BYTE;
    end else if (len_sel) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte && wrap) begin
            state_nxt = ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wrap) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!padding_r) begin
          state_nxt = ST_IDLE;
        end else if (last_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && (word_r == LAST_WORD)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    ctl       = '0;
    byte_mux  = pad_byte;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        byte_mux      = in_data.data_byte;
        ctl.load_byte = in_acc && in_data.has_byte;
        ctl.load_vars = in_acc && in_data.has_byte && wrap;
      end
      ST_PAD: begin
        ctl.load_byte = 1'b1;
        ctl.load_vars = wrap;
      end
      ST_ROUND: begin
        ctl.round_en = 1'b1;
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
      end
      ST_OUT: begin
        out_valid  = 1'b1;
        ctl.rotate = out_acc;
        ctl.reinit = out_acc && (word_r == LAST_WORD);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      count_r   <= '0;
      round_r   <= '0;
      word_r    <= '0;
      padding_r <= 1'b0;
      first_r   <= 1'b0;
      extra_r   <= 1'b0;
      last_r    <= 1'b0;
      len_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load_byte) begin
        pos_r <= pos_r + 6'd1;
      end
      if (state_r == ST_ROUND) begin
        round_r <= round_r + 6'd1;
      end
      if (out_acc) begin
        word_r <= word_r + 3'd1;
      end
      // Message length and start of padding.
      if (in_acc) begin
        if (in_data.has_byte) begin
          count_r <= count_inc;
        end
        if (in_data.end_of_message) begin
          padding_r <= 1'b1;
          first_r   <= 1'b1;
          len_r     <= {(in_data.has_byte ? count_inc : count_r), 3'b000};
        end
      end
      // Padding progress: marker placement, extra block, length bytes.
      if (state_r == ST_PAD) begin
        if (first_r) begin
          first_r <= 1'b0;
          extra_r <= (pos_r >= LEN_POS) && !wrap;
        end else if (wrap) begin
          extra_r <= 1'b0;
        end
        if (len_sel) begin
          len_r <= {len_r[55:0], 8'h00};
          if (wrap) begin
            last_r <= 1'b1;
          end
        end
      end
      // Digest fully delivered: back to a fresh message.
      if (ctl.reinit) begin
        count_r   <= '0;
        padding_r <= 1'b0;
        last_r    <= 1'b0;
      end
    end
  end

  assign out_data.digest_word = hash_head;
  assign out_data.word_index  = word_r;
  assign out_data.last_word   = (word_r == LAST_WORD);

  sha256_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .byte_in (byte_mux),
    .w_head  (w_head)
  );

  sha256_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .round_idx (round_r),
    .w         (w_head),
    .hash_head (hash_head)
  );

endmodule

FILE: rtl/core/sha256_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 block window and message schedule
// Sixteen 32-bit words that first gather the block one byte a cycle and then
// roll forward one schedule word per round, oldest word at the head.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                     clk,
  input  sha256_pkg::sha256_ctl_t  ctl,
  input  logic [7:0]               byte_in,
  output logic [31:0]              w_head
);
  import sha256_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] w_new;

  // Next schedule word from the rolling window.
  assign w_new  = small_s1(w_r[14]) + w_r[9] + small_s0(w_r[1]) + w_r[0];
  assign w_head = w_r[0];

  // Bytes shift in at the tail; rounds shift whole words out of the head.
  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], byte_in};
    end else if (ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule

FILE: rtl/core/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit and hash state
// One compression round per cycle on the working variables, the final fold
// into the hash words, and rotation of the hash words for readout.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sha256_pkg::sha256_ctl_t  ctl,
  input  logic [5:0]               round_idx,
  input  logic [31:0]              w,
  output logic [31:0]              hash_head
);
  import sha256_pkg::*;

  logic [31:0] hash_r [8];
  logic [31:0] var_r  [8];
  logic [31:0] t1;
  logic [31:0] t2;

  // Round function on a..h.
  assign t1 = var_r[7] + big_s1(var_r[4]) +
              (var_r[6] ^ (var_r[4] & (var_r[5] ^ var_r[6]))) +
              ROUND_K[round_idx] + w;
  assign t2 = big_s0(var_r[0]) +
              ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  assign hash_head = hash_r[0];

  // Hash words: initial values, fold after a block, rotate during readout.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.reinit) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= HASH_INIT[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + var_r[i];
      end
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        hash_r[i] <= hash_r[i+1];
      end
      hash_r[7] <= hash_r[0];
    end
  end

  // Working variables: loaded at block start, one round per cycle.
  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        var_r[i] <= hash_r[i];
      end
    end else if (ctl.round_en) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

endmodule

FILE: rtl/core/sha256_chk.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for digest ordering and input blocking.
// ----------------------------------------------------------------------------
module sha256_chk (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  sha256_pkg::sha256_in_t   in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  sha256_pkg::sha256_out_t  out_data
);
  import sha256_pkg::*;

  // No new byte beat is taken while digest words are pending.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while digest output pending");

  // An end beat always starts a busy period.
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_message) |=> in_stall)
    else $error("engine ready right after end of message");

  // Digest words follow each other in index order without gaps.
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_word) |=>
      (out_valid && (out_data.word_index == 3'($past(out_data.word_index) + 3'd1))))
    else $error("digest word sequence broken");

  // The last flag marks exactly the eighth word.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == LAST_WORD)))
    else $error("last_word does not match word_index");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed");

endmodule

bind sha256_message_digest sha256_chk u_chk (.*);

FILE: verif/sha256_message_digest_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams byte beats that make up whole messages into the engine and checks
// every digest word against an in-bench SHA-256 model. The run covers empty
// messages, byte-plus-end beats, ignored bytes, lengths that cross the
// padding and block boundaries, random gaps on both channels and one long
// receiver hold-off that backs the engine up into its input.
// ----------------------------------------------------------------------------
module sha256_message_digest_tb;

  localparam int RANDOM_BEATS = 220;
  localparam int IDLE_PCT     = 13;
  localparam int CALM_FROM    = 1200;
  localparam int CALM_TO      = 2200;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int LEN_FIELD_AT = 56;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha256_pkg::sha256_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha256_pkg::sha256_out_t out_data;

  // Stimulus and expectation stores.
  sha256_pkg::sha256_in_t  pending_beats [$];
  sha256_pkg::sha256_out_t digest_expect [$];
  sha256_pkg::sha256_out_t digest_want;

  // Shadow hashing state.
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] byte_total;

  int error_count   = 0;
  int beats_queued  = 0;
  int messages_done = 0;
  int bytes_hashed  = 0;
  int longest_msg   = 0;
  int words_checked = 0;
  int drv_cycle     = 0;
  int mon_cycle     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  sha256_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the current block into the chaining words.
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
    end
    for (int i = 0; i < 8; i++)
      v[i] = chain_words[i];
    for (int j = 0; j < 64; j++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[j] + sched[j];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--)
        v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_words[i] = chain_words[i] + v[i];
  endfunction

  // Shadow state after reset: initial chaining words, empty message.
  function automatic void clear_digest_state();
    for (int i = 0; i < 8; i++)
      chain_words[i] = IV_WORDS[i];
    byte_total = '0;
  endfunction

  // Apply one accepted beat; an end beat pads, finishes and queues eight words.
  function automatic void absorb_beat(input sha256_pkg::sha256_in_t beat);
    int pos;
    logic [63:0] bit_len;
    if (beat.has_byte) begin
      block_bytes[byte_total[5:0]] = beat.data_byte;
      byte_total = byte_total + 1'b1;
      bytes_hashed++;
      if (byte_total[5:0] == 6'd0)
        compress_block();
    end
    if (beat.end_of_message) begin
      if (byte_total > longest_msg)
        longest_msg = int'(byte_total);
      pos = int'(byte_total[5:0]);
      block_bytes[pos] = PAD_MARK;
      for (int k = pos + 1; k < 64; k++)
        block_bytes[k] = 8'h00;
      // No room left for the length field: finish this block, pad another.
      if (pos >= LEN_FIELD_AT) begin
        compress_block();
        for (int k = 0; k < LEN_FIELD_AT; k++)
          block_bytes[k] = 8'h00;
      end
      bit_len = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++)
        block_bytes[LEN_FIELD_AT + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_expect.push_back('{chain_words[i], 3'(i), (i == 7)});
      messages_done++;
      clear_digest_state();
    end
  endfunction

  // Queue one input beat; beats that carry neither a byte nor an end are noise.
  task automatic push_beat(input logic [7:0] d, input logic h, input logic e);
    pending_beats.push_back('{d, h, e});
    beats_queued++;
  endtask

  // Queue a whole message with random bytes and sprinkled noise beats.
  task automatic push_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 10)
        push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0)
      push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Driver: offers pending beats, predicts each beat the engine takes.
  always @(posedge clk) begin
    if (rst_n) begin
      drv_cycle <= drv_cycle + 1;
      if (in_valid && !in_stall)
        absorb_beat(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 &&
            ((drv_cycle >= CALM_FROM && drv_cycle < CALM_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each digest beat and drives the receiver's stall.
  always @(posedge clk) begin
    if (rst_n) begin
      mon_cycle <= mon_cycle + 1;
      if (out_valid && !out_stall) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest beat: word %h index %0d", out_data.digest_word,
                 out_data.word_index);
          error_count++;
        end else begin
          digest_want = digest_expect.pop_front();
          words_checked++;
          if (out_data.digest_word !== digest_want.digest_word) begin
            $error("digest_word: expected %h, got %h", digest_want.digest_word,
                   out_data.digest_word);
            error_count++;
          end
          if (out_data.word_index !== digest_want.word_index) begin
            $error("word_index: expected %0d, got %0d", digest_want.word_index,
                   out_data.word_index);
            error_count++;
          end
          if (out_data.last_word !== digest_want.last_word) begin
            $error("last_word: expected %0d, got %0d", digest_want.last_word,
                   out_data.last_word);
            error_count++;
          end
        end
      end
      // One long hold-off once results flow, no stalls in the calm window, else random.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && out_valid && mon_cycle >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (mon_cycle >= CALM_FROM && mon_cycle < CALM_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int len;
    int pick;
    clear_digest_state();

    // Directed: empty message, then another empty one right behind it.
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'h00, 1'b0, 1'b1);
    // Three bytes with the end on the last byte beat.
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    // Extreme bytes, a noise beat inside, then an end without a byte.
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'ha5, 1'b0, 1'b1);
    // Two single-byte messages, each byte also ending its message.
    push_beat(8'hff, 1'b1, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);

    // Random: one message near the length-field boundary, then a mix.
    push_message($urandom_range(55, 64), $urandom_range(0, 1));
    while (beats_queued < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        len = $urandom_range(0, 8);
      else if (pick < 80)
        len = $urandom_range(9, 40);
      else
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          4: len = 119;
          default: len = 120;
        endcase
      push_message(len, $urandom_range(0, 1));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid)
      @(posedge clk);
    while (digest_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d messages hashed, %0d bytes, longest %0d bytes",
             messages_done, bytes_hashed, longest_msg);
    $display("tb: %0d digest words checked, receiver held off %0d cycles once",
             words_checked, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: the slowest legal run finishes far sooner than this.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
